@@ design/bsoa_pkg.sv @@
// shared constants and types of the bit stream offset aligner
`default_nettype none

package bsoa_pkg;

    // sizing
    localparam int MAX_SHIFT      = 64;
    localparam int MAX_TRACK_BITS = 262144;
    localparam int CELLS          = 2 * MAX_SHIFT + 1;
    localparam int WIDE_W         = 3 * MAX_SHIFT + 1;
    localparam int POS_W          = $clog2(MAX_TRACK_BITS + 1);
    localparam int SHIFT_W        = $clog2(MAX_SHIFT + 1);
    localparam int AIDX_W         = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT) : 1;
    localparam int CELL_W         = $clog2(CELLS);

    // fixed field widths
    localparam int CNT_W      = 19;
    localparam int OFS_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int MOFS_W     = 7;
    localparam int FRAC_W     = 16;
    localparam int THR_W      = FRAC_W;
    localparam int PROD_W     = CNT_W + FRAC_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int SHORT_MARGIN = 16;

    localparam logic [MOFS_W-1:0] MOFS_RESET = 7'd64;
    localparam logic [THR_W-1:0]  THR_RESET  = 16'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_OFFSET = 1'b0,
        CFG_THRESHOLD  = 1'b1
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_SHORT  = 2'd1,
        ST_NO_FIT = 2'd2
    } status_t;

    typedef struct packed {
        logic take;
        logic clear;
        logic scan;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ design/bit_stream_offset_aligner.sv @@
// top level of the bit stream offset aligner
`default_nettype none

// Compares two revolutions of a track, fed as (a_bit, b_bit) pairs, against
// each other at every shift d from -max_offset to +max_offset and reports the
// shift with the fewest mismatching bits. A row of 2*MAX_SHIFT+1 offset cells
// holds the b history and one mismatch counter per shift; all cells update
// together, so a bit pair is taken every clock cycle while in_ready is high. The
// pair marked last closes the stream: the counters are then shifted out of the
// row one per cycle into the comparator at its head, which also clears them,
// followed by a multiply state for the reliability check and a state that loads
// the result register; no pairs are taken until the result is loaded. The load
// waits, and input stays blocked, while an earlier result still sits unaccepted
// in the result register. Pairs beyond MAX_TRACK_BITS in one stream are dropped
// until last. Register writes go through cfg_index/cfg_data and should be made
// between transactions.

module bit_stream_offset_aligner (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bsoa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bsoa_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                a_bit,
    input  wire logic                                b_bit,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [bsoa_pkg::STATUS_W-1:0]            status,
    output logic signed [bsoa_pkg::OFS_W-1:0]        best_offset,
    output logic [bsoa_pkg::CNT_W-1:0]               mismatch_bits,
    output logic [bsoa_pkg::CNT_W-1:0]               compared_bits,
    output logic                                     reliable
);

    logic [bsoa_pkg::MOFS_W-1:0]  max_offset_reg;
    logic [bsoa_pkg::THR_W-1:0]   threshold_reg;
    logic [bsoa_pkg::POS_W-1:0]   bit_pos_reg;
    logic [bsoa_pkg::POS_W-1:0]   bit_pos_next;
    logic [bsoa_pkg::POS_W-1:0]   len;
    logic [bsoa_pkg::SHIFT_W-1:0] span;
    logic                         accept;
    logic                         room;
    logic                         counting;
    logic                         pick_idle;
    logic                         pick_scan;
    logic                         a_old;
    bsoa_pkg::cell_ctrl_t         ctrl;

    logic [bsoa_pkg::CELLS-1:0]   b_q;
    logic [bsoa_pkg::CELLS:0]     b_wide;
    logic [bsoa_pkg::CELLS-1:0]   b_next;
    logic [bsoa_pkg::CELLS-1:0]   taps;
    logic [bsoa_pkg::CELLS-1:0]   active;
    logic [bsoa_pkg::CELLS-1:0]   hit;
    logic [bsoa_pkg::CNT_W-1:0]   cnt_q [bsoa_pkg::CELLS];

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_offset_reg <= bsoa_pkg::MOFS_RESET;
            threshold_reg  <= bsoa_pkg::THR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                bsoa_pkg::CFG_MAX_OFFSET: max_offset_reg <= cfg_data[bsoa_pkg::MOFS_W-1:0];
                bsoa_pkg::CFG_THRESHOLD:  threshold_reg  <= cfg_data[bsoa_pkg::THR_W-1:0];
                default:                  ;
            endcase
        end
    end

    assign span = (max_offset_reg > bsoa_pkg::MAX_SHIFT)
                ? bsoa_pkg::SHIFT_W'(bsoa_pkg::MAX_SHIFT)
                : bsoa_pkg::SHIFT_W'(max_offset_reg);

    // input transactions
    assign in_ready   = pick_idle;
    assign accept     = in_valid && in_ready;
    assign room       = bit_pos_reg < bsoa_pkg::POS_W'(bsoa_pkg::MAX_TRACK_BITS);
    assign ctrl.take  = accept && room;
    assign ctrl.clear = accept && last;
    assign ctrl.scan  = pick_scan;

    assign len = bit_pos_reg + bsoa_pkg::POS_W'(ctrl.take);

    always_comb
    begin
        bit_pos_next = bit_pos_reg;
        if (ctrl.clear)
        begin
            bit_pos_next = '0;
        end
        else if (ctrl.take)
        begin
            bit_pos_next = len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_pos_reg <= '0;
        end
        else
        begin
            bit_pos_reg <= bit_pos_next;
        end
    end

    // counting starts once the a delay and the b history are both full
    assign counting = bit_pos_reg >= bsoa_pkg::POS_W'({span, 1'b0});

    assign b_wide = {b_q, b_bit};
    assign b_next = b_wide[bsoa_pkg::CELLS-1:0];

    always_comb
    begin
        for (int c = 0; c < bsoa_pkg::CELLS; c++)
        begin
            active[c] = (c + int'(span) >= bsoa_pkg::MAX_SHIFT)
                     && (c <= bsoa_pkg::MAX_SHIFT + int'(span));
            hit[c]    = active[c] && counting && (a_old != taps[c]);
        end
    end

    bsoa_tap u_tap (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .a_bit  (a_bit),
        .span   (span),
        .b_next (b_next),
        .a_old  (a_old),
        .taps   (taps)
    );

    for (genvar g = 0; g < bsoa_pkg::CELLS; g++)
    begin : g_cell
        logic [bsoa_pkg::CNT_W-1:0] cnt_from;

        if (g == bsoa_pkg::CELLS - 1)
        begin : g_tail
            assign cnt_from = '0;
        end
        else
        begin : g_body
            assign cnt_from = cnt_q[g+1];
        end

        bsoa_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .b_prev  (b_next[g]),
            .hit     (hit[g]),
            .cnt_in  (cnt_from),
            .b_out   (b_q[g]),
            .cnt_out (cnt_q[g])
        );
    end

    bsoa_pick u_pick (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (ctrl.clear),
        .len           (len),
        .span          (span),
        .threshold     (threshold_reg),
        .cnt_head      (cnt_q[0]),
        .out_ready     (out_ready),
        .idle          (pick_idle),
        .scan          (pick_scan),
        .out_valid     (out_valid),
        .status        (status),
        .best_offset   (best_offset),
        .mismatch_bits (mismatch_bits),
        .compared_bits (compared_bits),
        .reliable      (reliable)
    );

endmodule

`default_nettype wire

@@ design/bsoa_cell.sv @@
// one offset cell: a bit of the b shift chain and the mismatch counter of one offset
`default_nettype none

module bsoa_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bsoa_pkg::cell_ctrl_t      ctrl,
    input  wire logic                      b_prev,
    input  wire logic                      hit,
    input  wire logic [bsoa_pkg::CNT_W-1:0] cnt_in,
    output logic                           b_out,
    output logic [bsoa_pkg::CNT_W-1:0]     cnt_out
);

    logic                       b_reg;
    logic                       b_next;
    logic [bsoa_pkg::CNT_W-1:0] cnt_reg;
    logic [bsoa_pkg::CNT_W-1:0] cnt_next;

    always_comb
    begin
        b_next = b_reg;
        if (ctrl.clear)
        begin
            b_next = 1'b0;
        end
        else if (ctrl.take)
        begin
            b_next = b_prev;
        end
    end

    // during readout the counters move one cell toward the head each cycle
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.scan)
        begin
            cnt_next = cnt_in;
        end
        else if (ctrl.take && hit)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg   <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            b_reg   <= b_next;
            cnt_reg <= cnt_next;
        end
    end

    assign b_out   = b_reg;
    assign cnt_out = cnt_reg;

endmodule

`default_nettype wire

@@ design/bsoa_tap.sv @@
// a delay line with span select, and the per-cell b tap selected by the span
`default_nettype none

module bsoa_tap (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bsoa_pkg::cell_ctrl_t        ctrl,
    input  wire logic                        a_bit,
    input  wire logic [bsoa_pkg::SHIFT_W-1:0] span,
    input  wire logic [bsoa_pkg::CELLS-1:0]  b_next,
    output logic                             a_old,
    output logic [bsoa_pkg::CELLS-1:0]       taps
);

    logic [bsoa_pkg::MAX_SHIFT-1:0] a_dl_reg;
    logic [bsoa_pkg::MAX_SHIFT-1:0] a_dl_next;
    logic [bsoa_pkg::MAX_SHIFT:0]   a_dl_shift;
    logic [bsoa_pkg::SHIFT_W-1:0]   span_dec;
    logic [bsoa_pkg::WIDE_W-1:0]    b_wide;
    logic [bsoa_pkg::WIDE_W-1:0]    b_shifted;

    assign a_dl_shift = {a_dl_reg, a_bit};

    always_comb
    begin
        a_dl_next = a_dl_reg;
        if (ctrl.clear)
        begin
            a_dl_next = '0;
        end
        else if (ctrl.take)
        begin
            a_dl_next = a_dl_shift[bsoa_pkg::MAX_SHIFT-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_dl_reg <= '0;
        end
        else
        begin
            a_dl_reg <= a_dl_next;
        end
    end

    // a bit from span pairs ago
    assign span_dec = span - 1'b1;
    assign a_old    = (span == '0) ? a_bit : a_dl_reg[span_dec[bsoa_pkg::AIDX_W-1:0]];

    // cell c compares against b of age span + MAX_SHIFT - c
    assign b_wide    = {b_next, {bsoa_pkg::MAX_SHIFT{1'b0}}};
    assign b_shifted = b_wide >> span;

    always_comb
    begin
        for (int c = 0; c < bsoa_pkg::CELLS; c++)
        begin
            taps[c] = b_shifted[2 * bsoa_pkg::MAX_SHIFT - c];
        end
    end

endmodule

`default_nettype wire

@@ design/bsoa_pick.sv @@
// counter readout, best offset search, reliability check and result register
`default_nettype none

module bsoa_pick (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [bsoa_pkg::POS_W-1:0]    len,
    input  wire logic [bsoa_pkg::SHIFT_W-1:0]  span,
    input  wire logic [bsoa_pkg::THR_W-1:0]    threshold,
    input  wire logic [bsoa_pkg::CNT_W-1:0]    cnt_head,
    input  wire logic                          out_ready,
    output logic                               idle,
    output logic                               scan,
    output logic                               out_valid,
    output logic [bsoa_pkg::STATUS_W-1:0]      status,
    output logic signed [bsoa_pkg::OFS_W-1:0]  best_offset,
    output logic [bsoa_pkg::CNT_W-1:0]         mismatch_bits,
    output logic [bsoa_pkg::CNT_W-1:0]         compared_bits,
    output logic                               reliable
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MUL  = 4'b0100,
        S_LOAD = 4'b1000
    } pick_state_t;

    pick_state_t                   state_reg;
    pick_state_t                   state_next;
    logic [bsoa_pkg::CELL_W-1:0]   scan_cnt_reg;
    logic [bsoa_pkg::CNT_W-1:0]    compared_reg;
    logic                          short_reg;
    logic                          found_reg;
    logic [bsoa_pkg::CNT_W-1:0]    best_cnt_reg;
    logic [bsoa_pkg::CELL_W-1:0]   best_idx_reg;
    logic [bsoa_pkg::SHIFT_W-1:0]  best_abs_reg;
    logic [bsoa_pkg::PROD_W-1:0]   prod_reg;

    bsoa_pkg::status_t             status_reg;
    logic [bsoa_pkg::OFS_W-1:0]    best_offset_reg;
    logic [bsoa_pkg::CNT_W-1:0]    mismatch_reg;
    logic [bsoa_pkg::CNT_W-1:0]    compared_out_reg;
    logic                          reliable_reg;
    logic                          out_valid_reg;

    logic [bsoa_pkg::POS_W:0]      short_limit;
    logic                          is_short;
    logic [bsoa_pkg::CNT_W-1:0]    compared_calc;
    logic                          cur_neg;
    logic [bsoa_pkg::CELL_W-1:0]   cur_abs_wide;
    logic [bsoa_pkg::SHIFT_W-1:0]  cur_abs;
    logic                          in_range;
    logic                          better;
    logic                          out_free;
    logic                          rel_calc;
    logic [bsoa_pkg::CELL_W:0]     best_d_wide;

    assign short_limit   = (bsoa_pkg::POS_W+1)'({span, 1'b0})
                         + (bsoa_pkg::POS_W+1)'(bsoa_pkg::SHORT_MARGIN);
    assign is_short      = {1'b0, len} <= short_limit;
    assign compared_calc = bsoa_pkg::CNT_W'(len - bsoa_pkg::POS_W'({span, 1'b0}));

    // head cell holds the counter of offset scan_cnt - MAX_SHIFT
    assign cur_neg      = scan_cnt_reg < bsoa_pkg::CELL_W'(bsoa_pkg::MAX_SHIFT);
    assign cur_abs_wide = cur_neg ? bsoa_pkg::CELL_W'(bsoa_pkg::MAX_SHIFT) - scan_cnt_reg
                                  : scan_cnt_reg - bsoa_pkg::CELL_W'(bsoa_pkg::MAX_SHIFT);
    assign cur_abs      = bsoa_pkg::SHIFT_W'(cur_abs_wide);
    assign in_range     = cur_abs <= span;

    // fewest mismatches, then smaller distance, then the negative side
    always_comb
    begin
        better = 1'b0;
        if (in_range)
        begin
            if (!found_reg)
            begin
                better = cnt_head < compared_reg;
            end
            else
            begin
                better = (cnt_head < best_cnt_reg)
                      || ((cnt_head == best_cnt_reg)
                          && ((cur_abs < best_abs_reg)
                              || ((cur_abs == best_abs_reg) && cur_neg)));
            end
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign rel_calc    = {best_cnt_reg, bsoa_pkg::FRAC_W'(0)} <= prod_reg;
    assign best_d_wide = {1'b0, best_idx_reg} - (bsoa_pkg::CELL_W+1)'(bsoa_pkg::MAX_SHIFT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == bsoa_pkg::CELL_W'(bsoa_pkg::CELLS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOAD && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            scan_cnt_reg <= '0;
            compared_reg <= compared_calc;
            short_reg    <= is_short;
            found_reg    <= 1'b0;
        end
        if (state_reg == S_SCAN)
        begin
            scan_cnt_reg <= scan_cnt_reg + 1'b1;
            if (better)
            begin
                found_reg    <= 1'b1;
                best_cnt_reg <= cnt_head;
                best_idx_reg <= scan_cnt_reg;
                best_abs_reg <= cur_abs;
            end
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= bsoa_pkg::PROD_W'(threshold) * bsoa_pkg::PROD_W'(compared_reg);
        end
        if (state_reg == S_LOAD && out_free)
        begin
            if (short_reg)
            begin
                status_reg       <= bsoa_pkg::ST_SHORT;
                best_offset_reg  <= '0;
                mismatch_reg     <= '0;
                compared_out_reg <= '0;
                reliable_reg     <= 1'b0;
            end
            else if (!found_reg)
            begin
                status_reg       <= bsoa_pkg::ST_NO_FIT;
                best_offset_reg  <= '0;
                mismatch_reg     <= '0;
                compared_out_reg <= compared_reg;
                reliable_reg     <= 1'b0;
            end
            else
            begin
                status_reg       <= bsoa_pkg::ST_OK;
                best_offset_reg  <= bsoa_pkg::OFS_W'(best_d_wide);
                mismatch_reg     <= best_cnt_reg;
                compared_out_reg <= compared_reg;
                reliable_reg     <= rel_calc;
            end
        end
    end

    assign idle          = state_reg == S_IDLE;
    assign scan          = state_reg == S_SCAN;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign best_offset   = $signed(best_offset_reg);
    assign mismatch_bits = mismatch_reg;
    assign compared_bits = compared_out_reg;
    assign reliable      = reliable_reg;

endmodule

`default_nettype wire
